// ===== sv/lius_pkg.sv =====
// ----------------------------------------------------------------------------
// lius_pkg
// Shared types and constants for the linear interpolation upsampler.
// ----------------------------------------------------------------------------
package lius_pkg;

    localparam int RATIO_W = 15;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd256;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } lius_state_t;

    // control from the sequencer to the interpolation stepper
    typedef struct packed
    {
        logic load;
        logic step;
    } lius_ctl_t;

endpackage

// ===== sv/linear_interp_upsampler.sv =====
// ----------------------------------------------------------------------------
// A stream's first beat is on the output in the cycle after it is taken.
// Other beats: the accept, division in the bit-serial divider, a load of the
// interpolation stepper, then g output beats for a gap of g, one per cycle
// while the output is not stalled; a gap of zero emits no beat. The block
// takes one input beat at a time, paced by the divider and the interpolation
// stepper. Reset clears stream state, ratio set to 1.0.
// ----------------------------------------------------------------------------
// linear_interp_upsampler
// Stretches a sample stream by a fixed-point ratio with linear interpolation.
// ----------------------------------------------------------------------------
module linear_interp_upsampler
    import lius_pkg::*;
#(
    parameter int FRAC_BITS   = 8,
    parameter int MAX_GAP     = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [RATIO_W-1:0]                  cfg_wdata,     // ratio_q7_8
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample_in
    input  logic                                s_axis_tuser,  // restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,  // sample_out
    output logic                                m_axis_tlast   // last_of_run
);

    localparam int DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int GAP_W     = $clog2(MAX_GAP + 1);
    localparam int DW        = SAMPLE_BITS + 1;
    localparam int RC_W      = GAP_W + FRAC_BITS;
    localparam int RATIO_MAX = MAX_GAP * (2 ** FRAC_BITS);

    lius_state_t              state_reg, state_next;
    logic [RATIO_W-1:0]       ratio_reg;
    logic                     started_reg, started_next;
    logic [FRAC_BITS-1:0]     frac_reg, frac_next;
    logic [SAMPLE_BITS-1:0]   last_sample_reg, last_sample_next;
    logic [SAMPLE_BITS-1:0]   prev_reg, prev_next;
    logic [GAP_W-1:0]         gap_reg, gap_next;
    logic                     neg_reg, neg_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]   out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    logic                     out_free;
    logic                     accept;
    logic [SAMPLE_BITS-1:0]   cur;
    logic [RC_W-1:0]          ratio_c;
    logic [RC_W:0]            frac_sum;
    logic [GAP_W-1:0]         gap_calc;
    logic [DW-1:0]            diff;
    logic [DW-1:0]            mag;
    logic                     div_start;
    logic                     div_done;
    logic [DW-1:0]            div_quot;
    logic [GAP_W-1:0]         div_rem;
    logic [DW:0]              qd;
    logic [GAP_W-1:0]         rd;
    lius_ctl_t                ctl;
    logic [SAMPLE_BITS-1:0]   ip_value;
    logic                     ip_last;

    lius_div #(
        .DW (DW),
        .GW (GAP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (gap_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    lius_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GW          (GAP_W)
    ) u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .prev  (prev_reg),
        .qd    (qd),
        .rd    (rd),
        .gap   (gap_reg),
        .value (ip_value),
        .last  (ip_last)
    );

    always_comb
    begin
        out_free      = !out_valid_reg || m_axis_tready;
        s_axis_tready = (state_reg == ST_IDLE) && out_free;
        accept        = s_axis_tvalid && s_axis_tready;
        cur           = s_axis_tdata[SAMPLE_BITS-1:0];

        // clamp the ratio so a gap never exceeds MAX_GAP
        if (32'(ratio_reg) > 32'(RATIO_MAX))
        begin
            ratio_c = RC_W'(RATIO_MAX);
        end
        else
        begin
            ratio_c = RC_W'(ratio_reg);
        end
        frac_sum = (RC_W+1)'(frac_reg) + (RC_W+1)'(ratio_c);
        gap_calc = GAP_W'(frac_sum >> FRAC_BITS);

        diff = {cur[SAMPLE_BITS-1], cur}
             - {last_sample_reg[SAMPLE_BITS-1], last_sample_reg};
        mag  = diff[DW-1] ? DW'(-diff) : diff;

        // signed floor division of diff by the gap
        if (neg_reg)
        begin
            qd = (div_rem == '0) ? (DW+1)'(-{1'b0, div_quot}) : ~{1'b0, div_quot};
            rd = (div_rem == '0) ? '0 : GAP_W'(gap_reg - div_rem);
        end
        else
        begin
            qd = {1'b0, div_quot};
            rd = div_rem;
        end

        state_next       = state_reg;
        started_next     = started_reg;
        frac_next        = frac_reg;
        last_sample_next = last_sample_reg;
        prev_next        = prev_reg;
        gap_next         = gap_reg;
        neg_next         = neg_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        div_start        = 1'b0;
        ctl              = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    started_next     = 1'b1;
                    last_sample_next = cur;
                    if (s_axis_tuser || !started_reg)
                    begin
                        // first beat of a stream passes straight through
                        frac_next      = '0;
                        out_valid_next = 1'b1;
                        out_data_next  = cur;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        frac_next = frac_sum[FRAC_BITS-1:0];
                        prev_next = last_sample_reg;
                        gap_next  = gap_calc;
                        neg_next  = diff[DW-1];
                        if (gap_calc != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctl.step       = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = ip_value;
                    out_last_next  = ip_last;
                    if (ip_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ratio_reg       <= RATIO_RESET;
            started_reg     <= 1'b0;
            frac_reg        <= '0;
            last_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            started_reg     <= started_next;
            frac_reg        <= frac_next;
            last_sample_reg <= last_sample_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                ratio_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        gap_reg      <= gap_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== sv/lius_div.sv =====
// ----------------------------------------------------------------------------
// lius_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module lius_div
    import lius_pkg::*;
#(
    parameter int DW = 17,
    parameter int GW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [GW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [GW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quot_reg, quot_next;
    logic [GW-1:0] rem_reg, rem_next;
    logic [GW:0]   shifted;
    logic [GW:0]   trial;
    logic          fits;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DW-1]};
        trial     = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DW-2:0], fits};
            rem_next  = fits ? trial[GW-1:0] : shifted[GW-1:0];
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/lius_interp.sv =====
// ----------------------------------------------------------------------------
// lius_interp
// Steps prev*g + diff*k as quotient and remainder over g, one k per cycle
// while ctl.step is set, and rounds each point toward zero.
// ----------------------------------------------------------------------------
module lius_interp
    import lius_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int GW          = 7
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lius_ctl_t              ctl,
    input  logic [SAMPLE_BITS-1:0] prev,
    input  logic [SAMPLE_BITS+1:0] qd,
    input  logic [GW-1:0]          rd,
    input  logic [GW-1:0]          gap,
    output logic [SAMPLE_BITS-1:0] value,
    output logic                   last
);

    localparam int QW = SAMPLE_BITS + 1;

    logic [QW-1:0] q_reg, q_next;
    logic [GW-1:0] r_reg, r_next;
    logic [GW-1:0] k_reg, k_next;
    logic [QW:0]   q_sum;
    logic [GW:0]   r_sum;
    logic          wrap;
    logic [QW-1:0] q_adv;
    logic [GW-1:0] r_adv;

    always_comb
    begin
        // floor-form advance by diff/g
        r_sum = {1'b0, r_reg} + {1'b0, rd};
        wrap  = r_sum >= {1'b0, gap};
        r_adv = wrap ? GW'(r_sum - {1'b0, gap}) : r_sum[GW-1:0];
        q_sum = {q_reg[QW-1], q_reg} + qd + (QW+1)'(wrap);
        q_adv = q_sum[QW-1:0];
        // floor to truncation: bump negative values with a remainder
        value = SAMPLE_BITS'(q_adv + QW'(q_adv[QW-1] && (r_adv != '0)));
        last  = k_reg == gap;

        q_next = q_reg;
        r_next = r_reg;
        k_next = k_reg;
        if (ctl.load)
        begin
            q_next = {prev[SAMPLE_BITS-1], prev};
            r_next = '0;
            k_next = GW'(1);
        end
        else if (ctl.step)
        begin
            q_next = q_adv;
            r_next = r_adv;
            k_next = k_reg + GW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

endmodule
